// File: sv/i2cra_pkg.sv
// Package for the I2C register access master: phase codes, stage codes,
// request and status codes. No dependencies.
`timescale 1ns / 1ps
package i2cra_pkg;

	typedef enum logic [16:0] {
		P_IDLE     = 17'b00000000000000001,
		P_ST_FREE  = 17'b00000000000000010,
		P_ST_LOW   = 17'b00000000000000100,
		P_TX_LOW   = 17'b00000000000001000,
		P_TX_HIGH  = 17'b00000000000010000,
		P_ACK_LOW  = 17'b00000000000100000,
		P_ACK_HIGH = 17'b00000000001000000,
		P_RS_REL   = 17'b00000000010000000,
		P_RS_SCLH  = 17'b00000000100000000,
		P_RS_LOW   = 17'b00000001000000000,
		P_RX_LOW   = 17'b00000010000000000,
		P_RX_HIGH  = 17'b00000100000000000,
		P_MA_LOW   = 17'b00001000000000000,
		P_MA_HIGH  = 17'b00010000000000000,
		P_SP_LOW   = 17'b00100000000000000,
		P_SP_HIGH  = 17'b01000000000000000,
		P_SP_REL   = 17'b10000000000000000
	} phase_t;

	typedef enum logic [1:0] {
		S_ADDR_W = 2'd0,
		S_REG    = 2'd1,
		S_DATA   = 2'd2,
		S_ADDR_R = 2'd3
	} stage_t;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BUS_BUSY = 2'd1;
	localparam logic [1:0] ST_ADDR_NAK = 2'd2;
	localparam logic [1:0] ST_DATA_NAK = 2'd3;

	localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] CFG_ACK_LIMIT   = 2'd1;

	localparam logic [7:0] HALF_PERIOD_RST = 8'd30;
	localparam logic [5:0] ACK_LIMIT_RST   = 6'd50;

	// one tick's result, carried from the engine to the output register
	typedef struct packed {
		logic       scl_out;
		logic       sda_pull_low;
		logic [7:0] rd_data;
		logic       rd_valid;
		logic       rd_last;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
	} result_t;

	// one accepted tick's input fields
	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] dev_addr;
		logic [7:0] reg_addr;
		logic [4:0] length;
		logic [7:0] wr_data;
		logic       sda_in;
	} item_t;

endpackage

// File: sv/i2c_register_access_master.sv
// I2C register access master, top level. Depends on i2cra_pkg, i2cra_engine.
// An accepted tick's result is registered. Throughput: one tick per cycle
// while in_stall is low; an output register and a skid stage let a new tick
// enter while a result waits. Reset (arst_n low) returns to idle, config to
// 30 ticks and 50 polls; the write buffer holds no reset value.
`timescale 1ns / 1ps
module i2c_register_access_master #(
	parameter int MAX_BYTES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [6:0] dev_addr,
	input  logic [7:0] reg_addr,
	input  logic [4:0] length,
	input  logic [7:0] wr_data,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_out,
	output logic       sda_pull_low,
	output logic [7:0] rd_data,
	output logic       rd_valid,
	output logic       rd_last,
	output logic       busy_res,
	output logic       done_res,
	output logic [1:0] status
);

	logic [7:0] half_period_q;
	logic [5:0] ack_limit_q;
	i2cra_pkg::item_t   item;
	i2cra_pkg::result_t res, out_q, skid_q;
	logic step, out_v_q, skid_v_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cra_pkg::HALF_PERIOD_RST;
			ack_limit_q   <= i2cra_pkg::ACK_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_index == i2cra_pkg::CFG_HALF_PERIOD) begin
				half_period_q <= cfg_data;
			end else if (cfg_index == i2cra_pkg::CFG_ACK_LIMIT) begin
				ack_limit_q <= cfg_data[5:0];
			end
		end
	end

	assign item = '{req_type: req_type, dev_addr: dev_addr, reg_addr: reg_addr,
		length: length, wr_data: wr_data, sda_in: sda_in};
	assign in_stall = skid_v_q;
	assign step = in_valid && !in_stall;

	i2cra_engine #(.MAX_BYTES(MAX_BYTES)) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item),
		.half_period (half_period_q),
		.ack_limit   (ack_limit_q),
		.res         (res)
	);

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || !out_stall) begin
				out_v_q  <= skid_v_q || step;
				skid_v_q <= 1'b0;
			end else if (step) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (step) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_v_q;
	assign scl_out      = out_q.scl_out;
	assign sda_pull_low = out_q.sda_pull_low;
	assign rd_data      = out_q.rd_data;
	assign rd_valid     = out_q.rd_valid;
	assign rd_last      = out_q.rd_last;
	assign busy_res     = out_q.busy_res;
	assign done_res     = out_q.done_res;
	assign status       = out_q.status;

endmodule

// File: sv/i2cra_wbuf.sv
// Write data buffer of the I2C register access master.
// No package dependencies; plain memory written on load, read through a
// registered port at the one byte address the engine needs next.
`timescale 1ns / 1ps
module i2cra_wbuf #(
	parameter int MAX_BYTES = 16,
	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem_q [MAX_BYTES];
	logic [7:0] rd_q;

	// store a loaded byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// fetch the next byte to send every cycle
	always_ff @(posedge clk) begin
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// File: sv/i2cra_engine.sv
// Bus sequencer of the I2C register access master: one input tick
// in, one result per tick out. Depends on i2cra_pkg and i2cra_wbuf.
`timescale 1ns / 1ps
module i2cra_engine #(
	parameter int MAX_BYTES = 16,
	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
	localparam int CW = $clog2(MAX_BYTES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  i2cra_pkg::item_t   item,
	input  logic [7:0]         half_period,
	input  logic [5:0]         ack_limit,
	output i2cra_pkg::result_t res
);

	i2cra_pkg::phase_t phase_q, phase_d;
	i2cra_pkg::stage_t stage_q, stage_d;
	logic [7:0]  htc_q, htc_d;
	logic [3:0]  bit_q, bit_d;
	logic [CW-1:0] byte_q, byte_d;
	logic [7:0]  shift_q, shift_d;
	logic [5:0]  polls_q, polls_d;
	logic [CW-1:0] load_q, load_d;
	logic [6:0]  dev_q, dev_d;
	logic [7:0]  reg_q, reg_d;
	logic [CW-1:0] len_q, len_d;
	logic        read_q, read_d;
	logic [1:0]  err_q, err_d;

	logic [7:0]  hp;
	logic [5:0]  lim;
	logic        buf_we;
	logic [AW-1:0] buf_ra;
	logic [7:0]  buf_rd;
	logic [CW-1:0] byte_nx;
	logic [CW:0] byte_p1;
	logic        more;
	logic [CW-1:0] len_cl;

	assign hp  = (half_period == 8'd0) ? 8'd1 : half_period;
	assign lim = (ack_limit == 6'd0) ? 6'd1 : ack_limit;
	assign byte_p1 = {1'b0, byte_q} + 1'b1;
	assign more = (byte_p1 < {1'b0, len_q});

	// clamp length to the buffer depth
	always_comb begin
		if (int'(item.length) > MAX_BYTES) begin
			len_cl = CW'(MAX_BYTES);
		end else begin
			len_cl = CW'(item.length);
		end
	end

	assign buf_we = step && (phase_q == i2cra_pkg::P_IDLE) &&
		(item.req_type == i2cra_pkg::REQ_LOAD) && (int'(load_q) < MAX_BYTES);

	// point the buffer at the byte that follows the current one while sending data, else at byte 0
	assign buf_ra = (stage_q == i2cra_pkg::S_DATA) ? byte_p1[AW-1:0] : '0;

	i2cra_wbuf #(.MAX_BYTES(MAX_BYTES)) u_wbuf (
		.clk     (clk),
		.wr_en   (buf_we),
		.wr_addr (load_q[AW-1:0]),
		.wr_data (item.wr_data),
		.rd_addr (buf_ra),
		.rd_data (buf_rd)
	);

	// sequence one tick
	always_comb begin
		i2cra_pkg::phase_t ph;
		logic done;
		phase_d = phase_q;
		stage_d = stage_q;
		htc_d   = htc_q;
		bit_d   = bit_q;
		byte_d  = byte_q;
		shift_d = shift_q;
		polls_d = polls_q;
		load_d  = load_q;
		dev_d   = dev_q;
		reg_d   = reg_q;
		len_d   = len_q;
		read_d  = read_q;
		err_d   = err_q;
		byte_nx = '0;
		res     = '0;
		res.scl_out = 1'b1;
		done = 1'b0;

		if (phase_q == i2cra_pkg::P_IDLE) begin
			if (item.req_type == i2cra_pkg::REQ_LOAD) begin
				if (int'(load_q) < MAX_BYTES) begin
					load_d = load_q + 1'b1;
				end
			end else if (item.req_type == i2cra_pkg::REQ_WRITE ||
				item.req_type == i2cra_pkg::REQ_READ) begin
				dev_d  = item.dev_addr;
				reg_d  = item.reg_addr;
				len_d  = len_cl;
				read_d = (item.req_type == i2cra_pkg::REQ_READ);
				err_d  = i2cra_pkg::ST_OK;
				htc_d  = '0;
				phase_d = i2cra_pkg::P_ST_FREE;
			end
		end
		ph = phase_d;
		res.busy_res = (ph != i2cra_pkg::P_IDLE);

		// drive the lines for the phase in effect
		unique case (ph)
			i2cra_pkg::P_ST_LOW, i2cra_pkg::P_RS_LOW, i2cra_pkg::P_SP_HIGH:
				res.sda_pull_low = 1'b1;
			i2cra_pkg::P_TX_LOW: begin
				res.scl_out = 1'b0;
				res.sda_pull_low = ~shift_q[7];
			end
			i2cra_pkg::P_TX_HIGH: res.sda_pull_low = ~shift_q[7];
			i2cra_pkg::P_ACK_LOW, i2cra_pkg::P_RS_REL, i2cra_pkg::P_RX_LOW:
				res.scl_out = 1'b0;
			i2cra_pkg::P_MA_LOW: begin
				res.scl_out = 1'b0;
				res.sda_pull_low = more;
			end
			i2cra_pkg::P_MA_HIGH: res.sda_pull_low = more;
			i2cra_pkg::P_SP_LOW: begin
				res.scl_out = 1'b0;
				res.sda_pull_low = 1'b1;
			end
			default: ;
		endcase

		// advance at the end of each half period
		if (res.busy_res) begin
			if ({1'b0, htc_d} + 9'd1 < {1'b0, hp}) begin
				htc_d = htc_d + 1'b1;
			end else begin
				htc_d = '0;
				unique case (ph)
					i2cra_pkg::P_ST_FREE: begin
						if (!item.sda_in) begin
							done = 1'b1;
							res.status = i2cra_pkg::ST_BUS_BUSY;
							phase_d = i2cra_pkg::P_IDLE;
						end else begin
							phase_d = i2cra_pkg::P_ST_LOW;
						end
					end
					i2cra_pkg::P_ST_LOW: begin
						if (item.sda_in) begin
							done = 1'b1;
							res.status = i2cra_pkg::ST_BUS_BUSY;
							phase_d = i2cra_pkg::P_IDLE;
						end else begin
							shift_d = {dev_q, 1'b0};
							bit_d = '0;
							stage_d = i2cra_pkg::S_ADDR_W;
							phase_d = i2cra_pkg::P_TX_LOW;
						end
					end
					i2cra_pkg::P_TX_LOW: phase_d = i2cra_pkg::P_TX_HIGH;
					i2cra_pkg::P_TX_HIGH: begin
						shift_d = {shift_q[6:0], 1'b0};
						bit_d = bit_q + 1'b1;
						if (bit_q == 4'd7) begin
							polls_d = '0;
							phase_d = i2cra_pkg::P_ACK_LOW;
						end else begin
							phase_d = i2cra_pkg::P_TX_LOW;
						end
					end
					i2cra_pkg::P_ACK_LOW: phase_d = i2cra_pkg::P_ACK_HIGH;
					i2cra_pkg::P_ACK_HIGH: begin
						if (!item.sda_in) begin
							case (stage_q)
								i2cra_pkg::S_ADDR_W: begin
									shift_d = reg_q;
									bit_d = '0;
									stage_d = i2cra_pkg::S_REG;
									phase_d = i2cra_pkg::P_TX_LOW;
								end
								i2cra_pkg::S_REG: begin
									if (read_q) begin
										phase_d = i2cra_pkg::P_RS_REL;
									end else if (len_q == '0) begin
										err_d = i2cra_pkg::ST_OK;
										phase_d = i2cra_pkg::P_SP_LOW;
									end else begin
										byte_d = '0;
										shift_d = buf_rd;
										bit_d = '0;
										stage_d = i2cra_pkg::S_DATA;
										phase_d = i2cra_pkg::P_TX_LOW;
									end
								end
								i2cra_pkg::S_DATA: begin
									byte_nx = byte_q + 1'b1;
									byte_d = byte_nx;
									if (more) begin
										shift_d = buf_rd;
										bit_d = '0;
										phase_d = i2cra_pkg::P_TX_LOW;
									end else begin
										err_d = i2cra_pkg::ST_OK;
										phase_d = i2cra_pkg::P_SP_LOW;
									end
								end
								default: begin
									if (len_q == '0) begin
										err_d = i2cra_pkg::ST_OK;
										phase_d = i2cra_pkg::P_SP_LOW;
									end else begin
										byte_d = '0;
										shift_d = '0;
										bit_d = '0;
										phase_d = i2cra_pkg::P_RX_LOW;
									end
								end
							endcase
						end else begin
							polls_d = polls_q + 1'b1;
							if (polls_d >= lim) begin
								err_d = (stage_q == i2cra_pkg::S_ADDR_W ||
									stage_q == i2cra_pkg::S_ADDR_R) ?
									i2cra_pkg::ST_ADDR_NAK : i2cra_pkg::ST_DATA_NAK;
								phase_d = i2cra_pkg::P_SP_LOW;
							end
						end
					end
					i2cra_pkg::P_RS_REL: phase_d = i2cra_pkg::P_RS_SCLH;
					i2cra_pkg::P_RS_SCLH: phase_d = i2cra_pkg::P_RS_LOW;
					i2cra_pkg::P_RS_LOW: begin
						shift_d = {dev_q, 1'b1};
						bit_d = '0;
						stage_d = i2cra_pkg::S_ADDR_R;
						phase_d = i2cra_pkg::P_TX_LOW;
					end
					i2cra_pkg::P_RX_LOW: phase_d = i2cra_pkg::P_RX_HIGH;
					i2cra_pkg::P_RX_HIGH: begin
						shift_d = {shift_q[6:0], item.sda_in};
						bit_d = bit_q + 1'b1;
						if (bit_q == 4'd7) begin
							res.rd_valid = 1'b1;
							res.rd_data = shift_d;
							res.rd_last = ~more;
							phase_d = i2cra_pkg::P_MA_LOW;
						end else begin
							phase_d = i2cra_pkg::P_RX_LOW;
						end
					end
					i2cra_pkg::P_MA_LOW: phase_d = i2cra_pkg::P_MA_HIGH;
					i2cra_pkg::P_MA_HIGH: begin
						byte_d = byte_q + 1'b1;
						if (more) begin
							shift_d = '0;
							bit_d = '0;
							phase_d = i2cra_pkg::P_RX_LOW;
						end else begin
							err_d = i2cra_pkg::ST_OK;
							phase_d = i2cra_pkg::P_SP_LOW;
						end
					end
					i2cra_pkg::P_SP_LOW: phase_d = i2cra_pkg::P_SP_HIGH;
					i2cra_pkg::P_SP_HIGH: phase_d = i2cra_pkg::P_SP_REL;
					default: begin
						done = 1'b1;
						res.status = err_q;
						phase_d = i2cra_pkg::P_IDLE;
					end
				endcase
				if (done && !read_q) begin
					load_d = '0;
				end
			end
		end
		res.done_res = done;
		if (!step) begin
			res = '0;
		end
	end

	// hold state between ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cra_pkg::P_IDLE;
			stage_q <= i2cra_pkg::S_ADDR_W;
			htc_q   <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			polls_q <= '0;
			load_q  <= '0;
			dev_q   <= '0;
			reg_q   <= '0;
			len_q   <= '0;
			read_q  <= 1'b0;
			err_q   <= i2cra_pkg::ST_OK;
		end else if (step) begin
			phase_q <= phase_d;
			stage_q <= stage_d;
			htc_q   <= htc_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			shift_q <= shift_d;
			polls_q <= polls_d;
			load_q  <= load_d;
			dev_q   <= dev_d;
			reg_q   <= reg_d;
			len_q   <= len_d;
			read_q  <= read_d;
			err_q   <= err_d;
		end
	end

endmodule

// File: sv/i2cra_checker.sv
// Port checker for the I2C register access master, bound to the top level.
// Depends on i2cra_pkg.
`timescale 1ns / 1ps
module i2cra_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       rd_valid,
	input logic       rd_last,
	input logic [7:0] rd_data,
	input logic       busy_res,
	input logic       done_res,
	input logic [1:0] status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done without busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == i2cra_pkg::ST_OK)
		else $error("status without done");

	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !rd_valid |-> !rd_last && rd_data == 8'd0)
		else $error("read fields without read byte");

endmodule

bind i2c_register_access_master i2cra_checker u_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.rd_valid(rd_valid), .rd_last(rd_last), .rd_data(rd_data),
	.busy_res(busy_res), .done_res(done_res), .status(status)
);
